// ===== rtl/core/dtq_pkg.sv =====
// Package for the deadline timer queue: word types, constants and controller states.
`default_nettype none
package dtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int MAX_RESULTS     = 16;
  localparam int FIELD_TIME_W    = 48;
  localparam int HANDLE_W        = 8;
  localparam int OCC_W           = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [FIELD_TIME_W-1:0] now_ms;
    logic [31:0]             relative_timeout;
    logic [HANDLE_W-1:0]     handle;
  } dtq_in_t;

  typedef struct packed {
    logic                    expired_valid;
    logic [HANDLE_W-1:0]     expired_handle;
    logic [FIELD_TIME_W-1:0] expired_deadline;
    logic                    last;
    logic                    queue_empty;
    logic [FIELD_TIME_W-1:0] earliest_deadline;
    logic                    overflow;
    logic [OCC_W-1:0]        occupancy;
  } dtq_out_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } dtq_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TICK
  } dtq_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/deadline_timer_queue.sv =====
// Sorted deadline timer queue: a row of shifting cells under one controller.
// Insert: busy in ST_INSERT, whose result word is registered; ticks emit from ST_TICK.
// Tick: one word per expired timer, up to MAX_RESULTS, else a single status word;
// words come one per cycle, set by the single pop per cycle through the cell row.
// Results are strobed by result_valid for one cycle each; the receiver cannot stall.
// Synchronous reset empties the queue and idles the controller; slot contents persist.
`default_nettype none
module deadline_timer_queue #(
  parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire  dtq_pkg::dtq_in_t request,
  output logic                   result_valid,
  output dtq_pkg::dtq_out_t      result
);
  import dtq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dtq_ctrl_t            ctrl;
  logic [CW-1:0]        count;
  logic [TIME_BITS-1:0] new_d;
  logic [HANDLE_W-1:0]  new_h;
  logic [TIME_BITS-1:0] cell_d    [QUEUE_DEPTH];
  logic [HANDLE_W-1:0]  cell_h    [QUEUE_DEPTH];
  logic                 cell_keep [QUEUE_DEPTH];

  dtq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result),
    .ctrl        (ctrl),
    .count       (count),
    .new_d       (new_d),
    .new_h       (new_h),
    .head_d      (cell_d[0]),
    .second_d    (cell_d[1]),
    .head_h      (cell_h[0]),
    .head_keep   (cell_keep[0])
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 lk;
    logic [TIME_BITS-1:0] ld, rd;
    logic [HANDLE_W-1:0]  lh, rh;

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign ld = new_d;
      assign lh = new_h;
    end else begin : g_mid
      assign lk = cell_keep[i-1];
      assign ld = cell_d[i-1];
      assign lh = cell_h[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign rd = '0;
      assign rh = '0;
    end else begin : g_inner
      assign rd = cell_d[i+1];
      assign rh = cell_h[i+1];
    end

    dtq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (CW'(i) < count),
      .new_d    (new_d),
      .new_h    (new_h),
      .left_keep(lk),
      .left_d   (ld),
      .left_h   (lh),
      .right_d  (rd),
      .right_h  (rh),
      .d        (cell_d[i]),
      .h        (cell_h[i]),
      .keep     (cell_keep[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/dtq_cell.sv =====
// One slot of the sorted queue: holds a deadline and handle, shifts left or right.
`default_nettype none
module dtq_cell #(
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire  dtq_pkg::dtq_ctrl_t         ctrl,
  input  wire                              occ,
  input  wire  [TIME_BITS-1:0]             new_d,
  input  wire  [dtq_pkg::HANDLE_W-1:0]     new_h,
  input  wire                              left_keep,
  input  wire  [TIME_BITS-1:0]             left_d,
  input  wire  [dtq_pkg::HANDLE_W-1:0]     left_h,
  input  wire  [TIME_BITS-1:0]             right_d,
  input  wire  [dtq_pkg::HANDLE_W-1:0]     right_h,
  output logic [TIME_BITS-1:0]             d,
  output logic [dtq_pkg::HANDLE_W-1:0]     h,
  output logic                             keep
);
  import dtq_pkg::*;

  // keep: this slot holds an entry due no later than the incoming one
  assign keep = occ && (d <= new_d);

  always_ff @(posedge clk) begin
    priority if (ctrl.pop) begin
      d <= right_d;
      h <= right_h;
    end else if (ctrl.ins && !keep) begin
      if (left_keep) begin
        d <= new_d;
        h <= new_h;
      end else begin
        d <= left_d;
        h <= left_h;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dtq_ctrl.sv =====
// Controller: accepts commands, sequences insert and tick, registers result words.
`default_nettype none
module dtq_ctrl #(
  parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  dtq_pkg::dtq_in_t       request,
  output logic                         result_valid,
  output dtq_pkg::dtq_out_t            result,
  output dtq_pkg::dtq_ctrl_t           ctrl,
  output logic [CW-1:0]                count,
  output logic [TIME_BITS-1:0]         new_d,
  output logic [dtq_pkg::HANDLE_W-1:0] new_h,
  input  wire  [TIME_BITS-1:0]         head_d,
  input  wire  [TIME_BITS-1:0]         second_d,
  input  wire  [dtq_pkg::HANDLE_W-1:0] head_h,
  input  wire                          head_keep
);
  import dtq_pkg::*;

  localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};
  localparam int NW = $clog2(MAX_RESULTS + 1);

  dtq_state_t           state, state_next;
  logic [CW-1:0]        count_next;
  logic [NW-1:0]        n_pop, n_pop_next;
  logic [TIME_BITS-1:0] now_reg;
  logic [TIME_BITS-1:0] now_in;
  logic [SUM_W-1:0]     sum;
  logic                 accept, full, due, tick_last;
  dtq_out_t             result_next;
  logic                 emit;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign now_in = TIME_BITS'(request.now_ms);
  assign sum    = SUM_W'(now_in) + SUM_W'(request.relative_timeout);
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign due    = (count != '0) && (head_d <= now_reg) && (n_pop != NW'(MAX_RESULTS));
  assign tick_last = (n_pop == NW'(MAX_RESULTS - 1)) || (count == CW'(1))
                     || (second_d > now_reg);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (request.operation == OP_TICK) ? ST_TICK : ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_TICK: begin
        if (!due || tick_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    count_next  = count;
    n_pop_next  = n_pop;
    emit        = 1'b0;
    result_next = '0;
    result_next.last              = 1'b1;
    result_next.queue_empty       = (count == '0);
    result_next.earliest_deadline = (count == '0) ? '0 : FIELD_TIME_W'(head_d);
    result_next.occupancy         = OCC_W'(count);
    unique case (state)
      ST_IDLE: n_pop_next = '0;
      ST_INSERT: begin
        emit = 1'b1;
        if (full) begin
          result_next.overflow = 1'b1;
        end else begin
          ctrl.ins   = 1'b1;
          count_next = count + CW'(1);
          result_next.queue_empty       = 1'b0;
          result_next.earliest_deadline = FIELD_TIME_W'(head_keep ? head_d : new_d);
          result_next.occupancy         = OCC_W'(count_next);
        end
      end
      ST_TICK: begin
        emit = 1'b1;
        if (due) begin
          ctrl.pop   = 1'b1;
          count_next = count - CW'(1);
          n_pop_next = n_pop + NW'(1);
          result_next.expired_valid     = 1'b1;
          result_next.expired_handle    = head_h;
          result_next.expired_deadline  = FIELD_TIME_W'(head_d);
          result_next.last              = tick_last;
          result_next.queue_empty       = (count_next == '0);
          result_next.earliest_deadline =
            (count_next == '0) ? '0 : FIELD_TIME_W'(second_d);
          result_next.occupancy         = OCC_W'(count_next);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      n_pop        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      n_pop        <= n_pop_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_reg <= now_in;
      new_d   <= (sum > SUM_W'(TIME_TOP)) ? TIME_TOP : sum[TIME_BITS-1:0];
      new_h   <= request.handle;
    end
    if (emit) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_deadline_timer_queue.sv =====
// Testbench for deadline_timer_queue: directed table then random words, checked against a queue model.
`timescale 1ns / 1ps
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam int          QDEPTH     = QUEUE_DEPTH_DEF;
  localparam logic [47:0] TIME_TOP   = 48'hFFFF_FFFF_FFFF;
  localparam int          QUIET_MAX  = 1000;
  localparam int          RAND_WORDS = 430;
  localparam int          CALM_TAIL  = 60;

  localparam dtq_out_t NOTHING_DUE = '{1'b0, 8'h00, 48'h0, 1'b1, 1'b1, 48'h0, 1'b0, 5'd0};

  typedef struct {
    dtq_in_t  req;
    bit       lit;
    dtq_out_t word;
  } step_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  dtq_in_t  request;
  logic     result_valid;
  dtq_out_t result;

  // literal expectation that replaces the modelled one for the word being sent
  bit       lit_on;
  dtq_out_t lit_word;

  logic [47:0] slot_deadline [QDEPTH];
  logic [7:0]  slot_handle [QDEPTH];
  int unsigned held;

  dtq_out_t  outcome_words[$];
  step_row_t dir_steps[$];
  dtq_out_t  want;
  int        errors;
  int        quiet;

  deadline_timer_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic dtq_out_t status_word(bit v, logic [7:0] h, logic [47:0] d, bit lst,
                                           bit ov);
    status_word = '{v, h, d, lst, held == 0, (held == 0) ? 48'h0 : slot_deadline[0], ov,
                    5'(held)};
  endfunction

  function automatic void queue_apply(dtq_in_t rq);
    logic [48:0] sum;
    logic [47:0] dl;
    logic [7:0]  hd;
    int          pos;
    int          due;
    if (rq.operation == OP_INSERT) begin
      sum = {1'b0, rq.now_ms} + {17'd0, rq.relative_timeout};
      dl  = sum[48] ? TIME_TOP : sum[47:0];
      if (held >= QDEPTH) begin
        outcome_words.push_back(status_word(1'b0, 8'h00, 48'h0, 1'b1, 1'b1));
        return;
      end
      pos = 0;
      while (pos < held && slot_deadline[pos] <= dl) pos++;
      for (int i = held; i > pos; i--) begin
        slot_deadline[i] = slot_deadline[i-1];
        slot_handle[i]   = slot_handle[i-1];
      end
      slot_deadline[pos] = dl;
      slot_handle[pos]   = rq.handle;
      held++;
      outcome_words.push_back(status_word(1'b0, 8'h00, 48'h0, 1'b1, 1'b0));
    end else begin
      due = 0;
      while (due < MAX_RESULTS && due < held && slot_deadline[due] <= rq.now_ms) due++;
      if (due == 0) begin
        outcome_words.push_back(status_word(1'b0, 8'h00, 48'h0, 1'b1, 1'b0));
        return;
      end
      for (int n = 0; n < due; n++) begin
        dl = slot_deadline[0];
        hd = slot_handle[0];
        for (int i = 1; i < held; i++) begin
          slot_deadline[i-1] = slot_deadline[i];
          slot_handle[i-1]   = slot_handle[i];
        end
        held--;
        outcome_words.push_back(status_word(1'b1, hd, dl, n == due - 1, 1'b0));
      end
    end
  endfunction

  function automatic dtq_in_t insert_word(logic [47:0] now, logic [31:0] rel, logic [7:0] h);
    insert_word = '{OP_INSERT, now, rel, h};
  endfunction

  function automatic dtq_in_t tick_word(logic [47:0] now);
    tick_word = '{OP_TICK, now, 32'h0, 8'h00};
  endfunction

  function automatic void add_step(dtq_in_t rq, bit lit, dtq_out_t w);
    step_row_t s;
    s.req  = rq;
    s.lit  = lit;
    s.word = w;
    dir_steps.push_back(s);
  endfunction

  task automatic check_field(string nm, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %h got %h", $time, nm, exp_v, got_v);
      errors++;
    end
  endtask

  // result check, prediction on acceptance, watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (result_valid) begin
        if (outcome_words.size() == 0) begin
          $display("%0t: unexpected word expected none got %p", $time, result);
          errors++;
        end else begin
          want = outcome_words.pop_front();
          check_field("expired_valid", want.expired_valid, result.expired_valid);
          check_field("expired_handle", want.expired_handle, result.expired_handle);
          check_field("expired_deadline", want.expired_deadline, result.expired_deadline);
          check_field("last", want.last, result.last);
          check_field("queue_empty", want.queue_empty, result.queue_empty);
          check_field("earliest_deadline", want.earliest_deadline, result.earliest_deadline);
          check_field("overflow", want.overflow, result.overflow);
          check_field("occupancy", want.occupancy, result.occupancy);
        end
      end
      if (start && !busy) begin
        queue_apply(request);
        if (lit_on) begin
          void'(outcome_words.pop_back());
          outcome_words.push_back(lit_word);
        end
      end
      if (result_valid || (start && !busy)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send(dtq_in_t rq, bit lit, dtq_out_t w);
    start    <= 1'b1;
    request  <= rq;
    lit_on   <= lit;
    lit_word <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    start  <= 1'b0;
    lit_on <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    idle_for(1);
    while (outcome_words.size() != 0 || busy) @(negedge clk);
  endtask

  initial begin
    dtq_in_t     rq;
    logic [63:0] rnd;
    logic [47:0] clock_ms;
    int          kind;
    int          sel;
    int          ins_share;
    rst      = 1'b1;
    start    = 1'b0;
    request  = '0;
    lit_on   = 1'b0;
    lit_word = '0;
    held     = 0;
    errors   = 0;
    quiet    = 0;
    for (int i = 0; i < QDEPTH; i++) begin
      slot_deadline[i] = '0;
      slot_handle[i]   = '0;
    end

    add_step(tick_word(48'h0), 1'b1, NOTHING_DUE);
    add_step(insert_word(TIME_TOP, 32'hFFFF_FFFF, 8'hFF), 1'b1,
             dtq_out_t'{1'b0, 8'h00, 48'h0, 1'b1, 1'b0, TIME_TOP, 1'b0, 5'd1});
    add_step(insert_word(48'h0, 32'h0, 8'h00), 1'b1,
             dtq_out_t'{1'b0, 8'h00, 48'h0, 1'b1, 1'b0, 48'h0, 1'b0, 5'd2});
    add_step(tick_word(48'h0), 1'b0, '0);
    add_step(insert_word(48'd100, 32'd5, 8'h01), 1'b0, '0);
    add_step(insert_word(48'd100, 32'd5, 8'h02), 1'b0, '0);
    add_step(insert_word(48'd103, 32'd2, 8'h03), 1'b0, '0);
    add_step(insert_word(48'd50, 32'd10, 8'h04), 1'b0, '0);
    add_step(tick_word(48'd59), 1'b0, '0);
    add_step(insert_word(48'h5555_5555_5555, 32'hAAAA_AAAA, 8'hAA), 1'b0, '0);
    add_step(insert_word(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 8'h55), 1'b0, '0);
    for (int k = 0; k < 9; k++)
      add_step(insert_word(48'd1000 + 48'(k), 32'(k * 3), 8'(8'h10 + k)), 1'b0, '0);
    // full queue: insert dropped
    add_step(insert_word(48'd0, 32'd1, 8'h77), 1'b1,
             dtq_out_t'{1'b0, 8'h00, 48'h0, 1'b1, 1'b0, 48'd60, 1'b1, 5'd16});
    add_step(tick_word(48'd150), 1'b0, '0);
    add_step(tick_word(TIME_TOP - 48'd1), 1'b0, '0);
    add_step(tick_word(TIME_TOP), 1'b0, '0);
    add_step(tick_word(TIME_TOP), 1'b1, NOTHING_DUE);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_steps[i]) begin
      if (i % 4 == 3) idle_for($urandom_range(1, 19));
      send(dir_steps[i].req, dir_steps[i].lit, dir_steps[i].word);
    end
    drain();

    clock_ms = 48'd0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 150 || i == 300) drain();
      if (i < RAND_WORDS - CALM_TAIL && $urandom_range(0, 5) == 0)
        idle_for($urandom_range(1, 19));
      ins_share = ((i / 40) % 2 == 1) ? 70 : 45;
      if ($urandom_range(0, 199) == 0) begin
        rnd      = {$urandom, $urandom};
        clock_ms = rnd[47:0];
      end else if ($urandom_range(0, 199) == 0) begin
        clock_ms = TIME_TOP - 48'($urandom_range(0, 2000));
      end
      rnd  = {$urandom, $urandom};
      kind = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      if (kind < ins_share) begin
        rq.operation = OP_INSERT;
        rq.now_ms    = (sel == 0) ? rnd[47:0] : clock_ms;
        case (sel)
          1: rq.relative_timeout = $urandom;
          2: rq.relative_timeout = 32'hFFFF_FFFF;
          3: rq.relative_timeout = 32'h0;
          default: rq.relative_timeout = $urandom_range(0, 400);
        endcase
      end else begin
        rq.operation        = OP_TICK;
        clock_ms            = clock_ms + 48'($urandom_range(0, 160));
        rq.now_ms           = (sel == 0) ? rnd[47:0] : (sel == 1) ? TIME_TOP : clock_ms;
        rq.relative_timeout = $urandom;
      end
      rq.handle = 8'($urandom_range(0, 255));
      send(rq, 1'b0, '0);
    end
    idle_for(1);

    while (outcome_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outcome_words.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
